// ----- hdl/mpa_pkg.sv -----
// Shared constants and helpers for the 2-D max pooling block with argmax.
// Used by mpa_cell, mpa_axis and max_pool_2d_argmax. No dependencies.
package mpa_pkg;

	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int SHAPE_W = 4;
	localparam int INDEX_W = 20;
	localparam int OUT_POS_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_IN_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_SIZE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DILATION = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_ORDER = 3'd6;

	// Kernel size after clamping, reduced so that (k-1)*d+1 fits in the extent.
	function automatic logic [4:0] fit_kernel(input logic [SHAPE_W-1:0] kf,
			input logic [SHAPE_W-1:0] df, input logic [4:0] ext);
		logic [4:0] kk;
		logic [4:0] cap;
		logic [SHAPE_W-1:0] dd;
		logic [8:0] span;
		dd = (df == '0) ? SHAPE_W'(1) : df;
		kk = (kf == '0) ? 5'd1 : {1'b0, kf};
		if (kk > ext) begin
			kk = ext;
		end
		cap = 5'd1;
		for (int n = 2; n <= 16; n++) begin
			span = 9'(n - 1) * {5'b0, dd};
			if (5'(n) <= ext && span <= ({4'b0, ext} - 9'd1)) begin
				cap = 5'(n);
			end
		end
		return (kk < cap) ? kk : cap;
	endfunction

endpackage

// ----- hdl/mpa_cell.sv -----
// One tap of the window-phase history line: holds the quotient and remainder
// of an earlier position and hands them to its neighbor. Uses mpa_pkg.
module mpa_cell import mpa_pkg::*; #(
	parameter int QW = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clr,
	input  logic               shift,
	input  logic               in_neg,
	input  logic [SHAPE_W-1:0] in_rem,
	input  logic [QW-1:0]      in_quot,
	input  logic [QW-2:0]      outn,
	output logic               neg,
	output logic [SHAPE_W-1:0] rem,
	output logic [QW-1:0]      quot,
	output logic               ok
);

	logic               neg_q;
	logic [SHAPE_W-1:0] rem_q;
	logic [QW-1:0]      quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b1;
		end else if (clr) begin
			neg_q <= 1'b1;
		end else if (shift) begin
			neg_q <= in_neg;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			rem_q <= in_rem;
			quot_q <= in_quot;
		end
	end

	assign neg = neg_q;
	assign rem = rem_q;
	assign quot = quot_q;
	// A window starts at an offset position that is a stride multiple below outn.
	assign ok = !neg_q && rem_q == '0 && quot_q < {1'b0, outn};

endmodule

// ----- hdl/mpa_axis.sv -----
// Window hit decoder for one axis: a phase counter for the current position
// followed by a chain of mpa_cell taps holding earlier positions. Uses mpa_pkg.
module mpa_axis import mpa_pkg::*; #(
	parameter int PW = 13,
	parameter int EXT = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clr,
	input  logic               step,
	input  logic [PW-1:0]      pos,
	input  logic [PW-1:0]      lim,
	input  logic [PW-1:0]      outn,
	input  logic [4:0]         k,
	input  logic [SHAPE_W-1:0] s,
	input  logic [SHAPE_W-1:0] d,
	output logic [EXT-1:0]     hit,
	output logic [PW:0]        quot [EXT]
);

	localparam int QW = PW + 1;
	localparam int TW = $clog2(EXT);
	localparam int RW = TW + 2;

	logic                     neg_q;
	logic signed [RW-1:0]     raw_q;
	logic [SHAPE_W-1:0]       rem_q;
	logic [QW-1:0]            quot_q;
	logic                     tap_neg [EXT];
	logic [SHAPE_W-1:0]       tap_rem [EXT];
	logic [QW-1:0]            tap_quot [EXT];
	logic                     tap_ok [EXT];
	logic                     edge_hit;

	// The counter tracks pos plus pad; it starts below zero and is stepped
	// through the pad during the preroll after a clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b1;
			raw_q <= -RW'(EXT);
			rem_q <= '0;
			quot_q <= '0;
		end else if (clr) begin
			neg_q <= 1'b1;
			raw_q <= -RW'(EXT);
			rem_q <= '0;
			quot_q <= '0;
		end else if (step) begin
			if (neg_q) begin
				if (raw_q == -RW'(1)) begin
					neg_q <= 1'b0;
					rem_q <= '0;
					quot_q <= '0;
				end else begin
					raw_q <= raw_q + RW'(1);
				end
			end else if (rem_q == s - SHAPE_W'(1)) begin
				rem_q <= '0;
				quot_q <= quot_q + QW'(1);
			end else begin
				rem_q <= rem_q + SHAPE_W'(1);
			end
		end
	end

	assign tap_neg[0] = neg_q;
	assign tap_rem[0] = rem_q;
	assign tap_quot[0] = quot_q;
	assign tap_ok[0] = !neg_q && rem_q == '0 && quot_q < {1'b0, outn};

	for (genvar j = 1; j < EXT; j++) begin : g_cell
		mpa_cell #(.QW(QW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.clr     (clr),
			.shift   (step),
			.in_neg  (tap_neg[j-1]),
			.in_rem  (tap_rem[j-1]),
			.in_quot (tap_quot[j-1]),
			.outn    (outn),
			.neg     (tap_neg[j]),
			.rem     (tap_rem[j]),
			.quot    (tap_quot[j]),
			.ok      (tap_ok[j])
		);
	end

	assign edge_hit = ({1'b0, pos} + QW'(d)) >= {1'b0, lim};

	// Kernel tap t ends its window here when t is the last tap, or when the
	// next tap would fall past the plane edge.
	always_comb begin
		logic [8:0] j;
		for (int t = 0; t < EXT; t++) begin
			j = 9'(t) * {5'b0, d};
			hit[t] = 1'b0;
			quot[t] = '0;
			if (9'(t) < {4'b0, k} && j < 9'(EXT)) begin
				quot[t] = tap_quot[j[TW-1:0]];
				hit[t] = tap_ok[j[TW-1:0]] && (5'(t) == k - 5'd1 || edge_hit);
			end
		end
	end

endmodule

// ----- hdl/max_pool_2d_argmax.sv -----
// Top level of the 2-D max pooling block with argmax over one channel plane.
// Depends on mpa_pkg, mpa_axis (row and column hit decoders) and mpa_cell.
//
// Channel   Signals                                        Direction
// config    cfg_we, cfg_index, cfg_data                    in
// input     in_valid, in_stall, sample                     in (stall out)
// result    out_valid, out_stall, max_value, max_index,    out (stall in)
//           out_row, out_col, last
//
// A sample that completes no window passes through the transfer and a pick
// step. Each window it completes adds a setup step, a line store read and a
// compare per window position inside the plane, a read alone per position
// outside it, the index multiply and the result transfer, which waits while
// out_stall is high. Each window row it touches adds one more pick step. The
// line store read port, one entry per read step, paces the window walk. After the
// last sample of a row a preroll steps the column decoder through the left
// pad; at the end of a plane the top pad preroll runs alongside it, so it lasts
// until the longer of the two ends. Reset and configuration writes start that
// plane preroll. in_stall is high whenever the block is not waiting for a sample.
module max_pool_2d_argmax import mpa_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_EXTENT = 8,
	parameter int DATA_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] sample,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] max_value,
	output logic [INDEX_W-1:0]           max_index,
	output logic [OUT_POS_W-1:0]         out_row,
	output logic [OUT_POS_W-1:0]         out_col,
	output logic                         last
);

	localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int PW = $clog2(MAX_DIM + 1);
	localparam int CW = PW + 2;
	localparam int TW = $clog2(MAX_EXTENT);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int DEPTH = MAX_EXTENT * MAX_WIDTH;
	localparam int AW = $clog2(DEPTH);
	localparam int PRE_W = $clog2(15 + MAX_EXTENT + 1);

	typedef enum logic [6:0] {
		S_INIT = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_PICK = 7'b0000100,
		S_RD   = 7'b0001000,
		S_CMP  = 7'b0010000,
		S_MUL  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]   in_size_q, out_size_q;
	logic [7:0]         kernel_q, stride_q, pad_q, dilation_q;
	logic               order_q;

	logic [PW-1:0]      h, w, oh, ow;
	logic [4:0]         kh, kw;
	logic [SHAPE_W-1:0] sv, sh, dv, dh, pv, ph;

	logic [PW-1:0]      r_q, c_q;
	logic [TW-1:0]      wslot_q;
	logic [PRE_W-1:0]   pre_r_q, pre_c_q;
	logic               rpre_q;

	logic [MAX_EXTENT-1:0] hit_r, hit_c, rmask_q, cmask_q;
	logic [PW:0]        quot_r [MAX_EXTENT];
	logic [PW:0]        quot_c [MAX_EXTENT];
	logic [TW-1:0]      rt, ct;

	logic signed [CW-1:0] y_q, x_q, bc_q;
	logic [4:0]         ky_q, kx_q;
	logic [PW:0]        orow_q, ocol_q;
	logic               last_pend_q, plane_end_q;
	logic               have_q;
	logic signed [DATA_WIDTH-1:0] best_q;
	logic [PW-1:0]      by_q, bx_q;

	logic [DATA_WIDTH-1:0] line_q [DEPTH];
	logic [DATA_WIDTH-1:0] rd_q;

	logic signed [DATA_WIDTH-1:0] max_value_q;
	logic [INDEX_W-1:0] max_index_q;
	logic [OUT_POS_W-1:0] out_row_q, out_col_q;
	logic               last_q;

	logic cfg_hit, accept, adv, c_last, r_last, col_pre_go, row_pre_go;
	logic row_clr, col_clr, row_step, col_step;
	logic inb, kx_more, ky_more;
	logic [TW-1:0] yoff;
	logic [TW:0]   slot_w;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [8:0]    toff_r, toff_c;

	function automatic logic [PW-1:0] clamp_dim(input logic [11:0] v,
			input logic [12:0] mx, input logic zero_to_one);
		logic [12:0] t;
		t = {1'b0, v};
		if (zero_to_one && v == '0) begin
			t = 13'd1;
		end else if (t > mx) begin
			t = mx;
		end
		return PW'(t);
	endfunction

	function automatic logic [TW-1:0] top_bit(input logic [MAX_EXTENT-1:0] m);
		logic [TW-1:0] res;
		res = '0;
		for (int i = 0; i < MAX_EXTENT; i++) begin
			if (m[i]) begin
				res = TW'(i);
			end
		end
		return res;
	endfunction

	// Geometry decode with the saturation and fallback rules.
	always_comb begin
		h = clamp_dim(in_size_q[23:12], 13'(MAX_HEIGHT), 1'b1);
		w = clamp_dim(in_size_q[11:0], 13'(MAX_WIDTH), 1'b1);
		oh = clamp_dim(out_size_q[23:12], 13'(MAX_HEIGHT), 1'b0);
		ow = clamp_dim(out_size_q[11:0], 13'(MAX_WIDTH), 1'b0);
		kh = fit_kernel(kernel_q[7:4], dilation_q[7:4], 5'(MAX_EXTENT));
		kw = fit_kernel(kernel_q[3:0], dilation_q[3:0], 5'(MAX_EXTENT));
		dv = (dilation_q[7:4] == '0) ? SHAPE_W'(1) : dilation_q[7:4];
		dh = (dilation_q[3:0] == '0) ? SHAPE_W'(1) : dilation_q[3:0];
		sv = (stride_q[7:4] == '0) ? SHAPE_W'(1) : stride_q[7:4];
		sh = (stride_q[3:0] == '0) ? SHAPE_W'(1) : stride_q[3:0];
		pv = pad_q[7:4];
		ph = pad_q[3:0];
	end

	mpa_axis #(.PW(PW), .EXT(MAX_EXTENT)) u_row_axis (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (row_clr),
		.step   (row_step),
		.pos    (r_q),
		.lim    (h),
		.outn   (oh),
		.k      (kh),
		.s      (sv),
		.d      (dv),
		.hit    (hit_r),
		.quot   (quot_r)
	);

	mpa_axis #(.PW(PW), .EXT(MAX_EXTENT)) u_col_axis (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (col_clr),
		.step   (col_step),
		.pos    (c_q),
		.lim    (w),
		.outn   (ow),
		.k      (kw),
		.s      (sh),
		.d      (dh),
		.hit    (hit_c),
		.quot   (quot_c)
	);

	always_comb begin
		cfg_hit = cfg_we && cfg_index <= REG_INDEX_ORDER;
		accept = state_q == S_IDLE && in_valid;
		adv = state_q == S_PICK && rmask_q == '0;
		c_last = c_q == w - PW'(1);
		r_last = r_q == h - PW'(1);
		col_pre_go = {3'b0, pre_c_q} < (8'(ph) + 8'(MAX_EXTENT));
		row_pre_go = rpre_q && ({3'b0, pre_r_q} < (8'(pv) + 8'(MAX_EXTENT)));
		col_clr = cfg_hit || (adv && c_last);
		row_clr = cfg_hit || (adv && c_last && r_last);
		col_step = !cfg_hit && ((state_q == S_INIT && col_pre_go) || (adv && !c_last));
		row_step = !cfg_hit && ((state_q == S_INIT && row_pre_go) || (adv && c_last && !r_last));
		in_stall = state_q != S_IDLE;
		rt = top_bit(rmask_q);
		ct = top_bit(cmask_q);
		toff_r = 9'(rt) * {5'b0, dv};
		toff_c = 9'(ct) * {5'b0, dh};
		inb = !y_q[CW-1] && y_q < $signed({2'b0, h}) && !x_q[CW-1] && x_q < $signed({2'b0, w});
		kx_more = kx_q + 5'd1 < kw;
		ky_more = ky_q + 5'd1 < kh;
		// Rows above the current one sit in earlier slots of the line store.
		yoff = TW'($signed({2'b0, r_q}) - y_q);
		if (wslot_q >= yoff) begin
			slot_w = {1'b0, wslot_q} - {1'b0, yoff};
		end else begin
			slot_w = {1'b0, wslot_q} + (TW + 1)'(MAX_EXTENT) - {1'b0, yoff};
		end
		rd_addr = AW'(slot_w) * AW'(MAX_WIDTH) + AW'(x_q[XW-1:0]);
		wr_addr = AW'(wslot_q) * AW'(MAX_WIDTH) + AW'(c_q[XW-1:0]);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_q[wr_addr] <= DATA_WIDTH'(sample);
		end
		if (state_q == S_RD && inb) begin
			rd_q <= line_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			in_size_q <= CFG_W'(4097);
			out_size_q <= CFG_W'(4097);
			kernel_q <= 8'd17;
			stride_q <= 8'd17;
			pad_q <= 8'd0;
			dilation_q <= 8'd17;
			order_q <= 1'b0;
			r_q <= '0;
			c_q <= '0;
			wslot_q <= '0;
			pre_r_q <= '0;
			pre_c_q <= '0;
			rpre_q <= 1'b1;
			rmask_q <= '0;
			cmask_q <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_IN_SIZE: in_size_q <= cfg_data;
				REG_OUT_SIZE: out_size_q <= cfg_data;
				REG_KERNEL: kernel_q <= cfg_data[7:0];
				REG_STRIDE: stride_q <= cfg_data[7:0];
				REG_PAD: pad_q <= cfg_data[7:0];
				REG_DILATION: dilation_q <= cfg_data[7:0];
				REG_INDEX_ORDER: order_q <= cfg_data[0];
				default: order_q <= order_q;
			endcase
			state_q <= S_INIT;
			r_q <= '0;
			c_q <= '0;
			wslot_q <= '0;
			pre_r_q <= '0;
			pre_c_q <= '0;
			rpre_q <= 1'b1;
		end else begin
			case (state_q)
				S_INIT: begin
					if (col_pre_go) begin
						pre_c_q <= pre_c_q + PRE_W'(1);
					end
					if (row_pre_go) begin
						pre_r_q <= pre_r_q + PRE_W'(1);
					end
					if (!col_pre_go && !row_pre_go) begin
						rpre_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						rmask_q <= hit_r;
						cmask_q <= hit_c;
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					if (adv) begin
						if (c_last) begin
							c_q <= '0;
							pre_c_q <= '0;
							state_q <= S_INIT;
							if (r_last) begin
								r_q <= '0;
								wslot_q <= '0;
								pre_r_q <= '0;
								rpre_q <= 1'b1;
							end else begin
								r_q <= r_q + PW'(1);
								wslot_q <= (wslot_q == TW'(MAX_EXTENT - 1)) ? '0 :
									wslot_q + TW'(1);
							end
						end else begin
							c_q <= c_q + PW'(1);
							state_q <= S_IDLE;
						end
					end else if (cmask_q == '0) begin
						rmask_q[rt] <= 1'b0;
						cmask_q <= hit_c;
					end else begin
						cmask_q[ct] <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (inb) begin
						state_q <= S_CMP;
					end else if (!kx_more && !ky_more) begin
						state_q <= S_MUL;
					end
				end
				S_CMP: begin
					state_q <= (!kx_more && !ky_more) ? S_MUL : S_RD;
				end
				S_MUL: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_PICK;
					end
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	// Window walk, running maximum and result registers; the first strict maximum wins.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				plane_end_q <= r_last && c_last;
			end
			S_PICK: begin
				y_q <= $signed({2'b0, r_q}) - CW'(toff_r);
				x_q <= $signed({2'b0, c_q}) - CW'(toff_c);
				bc_q <= $signed({2'b0, c_q}) - CW'(toff_c);
				ky_q <= '0;
				kx_q <= '0;
				have_q <= 1'b0;
				orow_q <= quot_r[rt];
				ocol_q <= quot_c[ct];
				last_pend_q <= plane_end_q
					&& (rmask_q & ~(MAX_EXTENT'(1) << rt)) == '0
					&& (cmask_q & ~(MAX_EXTENT'(1) << ct)) == '0;
			end
			S_RD, S_CMP: begin
				if (state_q == S_CMP && (!have_q || $signed(rd_q) > best_q)) begin
					have_q <= 1'b1;
					best_q <= $signed(rd_q);
					by_q <= y_q[PW-1:0];
					bx_q <= x_q[PW-1:0];
				end
				if (state_q == S_CMP || !inb) begin
					if (kx_more) begin
						kx_q <= kx_q + 5'd1;
						x_q <= x_q + CW'(dh);
					end else if (ky_more) begin
						ky_q <= ky_q + 5'd1;
						kx_q <= '0;
						x_q <= bc_q;
						y_q <= y_q + CW'(dv);
					end
				end
			end
			S_MUL: begin
				max_value_q <= best_q;
				max_index_q <= order_q ? INDEX_W'(bx_q * h + (2 * PW)'(by_q))
					: INDEX_W'(by_q * w + (2 * PW)'(bx_q));
				out_row_q <= OUT_POS_W'(orow_q);
				out_col_q <= OUT_POS_W'(ocol_q);
				last_q <= last_pend_q;
			end
			default: begin
				have_q <= have_q;
			end
		endcase
	end

	assign out_valid = state_q == S_OUT;
	assign max_value = max_value_q;
	assign max_index = max_index_q;
	assign out_row = out_row_q;
	assign out_col = out_col_q;
	assign last = last_q;

endmodule

// ----- test/tb_max_pool_2d_argmax.sv -----
// Self-checking testbench for max_pool_2d_argmax: 2-D max pooling with argmax.
// Holds its own pooling predictor and compares every result transfer against it.
// Depends on mpa_pkg and the max_pool_2d_argmax RTL.
`timescale 1ns / 1ps

module tb_max_pool_2d_argmax;
	import mpa_pkg::*;

	localparam int MAXW = 1024;
	localparam int MAXH = 1024;
	localparam int EXT = 8;
	localparam int WIN_CAP = 64;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int SETTLE = 300;

	typedef struct packed {
		logic signed [15:0] value;
		logic [INDEX_W-1:0] index;
		logic [OUT_POS_W-1:0] row;
		logic [OUT_POS_W-1:0] col;
		logic last;
	} pool_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] sample;
	logic out_valid;
	logic out_stall;
	logic signed [15:0] max_value;
	logic [INDEX_W-1:0] max_index;
	logic [OUT_POS_W-1:0] out_row;
	logic [OUT_POS_W-1:0] out_col;
	logic last;

	// Predictor state.
	logic signed [15:0] row_buf [EXT*MAXW];
	int cur_row, cur_col;
	logic [23:0] r_in_size, r_out_size;
	logic [7:0] r_kernel, r_stride, r_pad, r_dilation;
	logic r_col_major;

	pool_res_t pending_windows[$];
	int mismatches;
	int results_seen;
	int samples_sent;
	int configs_done;
	longint cycles;
	bit calm;
	bit hold_on;
	int rx_gap;

	max_pool_2d_argmax dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.max_value(max_value), .max_index(max_index),
		.out_row(out_row), .out_col(out_col), .last(last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int clamp_dim(input int v, input int lim, input bit zero_to_one);
		if (v == 0 && zero_to_one)
			return 1;
		return (v > lim) ? lim : v;
	endfunction

	task automatic fit_axis(input int kf, input int df, output int k, output int d);
		k = clamp_dim(kf, EXT, 1'b1);
		d = (df == 0) ? 1 : df;
		if ((k - 1) * d + 1 > EXT)
			k = (EXT - 1) / d + 1;
	endtask

	// Output indices along one axis whose last real coordinate is pos.
	task automatic axis_windows(input int pos, input int lim, input int outn, input int k,
			input int s, input int p, input int d, output int list [EXT], output int n);
		int b, q;
		n = 0;
		for (int t = k - 1; t >= 0; t--) begin
			b = pos - t * d;
			q = b + p;
			if (t != k - 1 && b + (t + 1) * d <= lim - 1)
				continue;
			if (q < 0 || q % s != 0)
				continue;
			if (q / s >= outn)
				continue;
			list[n] = q / s;
			n++;
		end
	endtask

	task automatic pool_sample(input logic signed [15:0] s);
		int h, w, oh, ow, kh, kw, dv, dh, sv, sh, pv, ph;
		int rows [EXT];
		int cols [EXT];
		int nr, nc, n, y, x, br, bc;
		bit have;
		logic signed [15:0] best;
		logic [31:0] bidx;
		pool_res_t res;
		h = clamp_dim(r_in_size[23:12], MAXH, 1'b1);
		w = clamp_dim(r_in_size[11:0], MAXW, 1'b1);
		oh = clamp_dim(r_out_size[23:12], MAXH, 1'b0);
		ow = clamp_dim(r_out_size[11:0], MAXW, 1'b0);
		fit_axis(r_kernel[7:4], r_dilation[7:4], kh, dv);
		fit_axis(r_kernel[3:0], r_dilation[3:0], kw, dh);
		sv = (r_stride[7:4] == 0) ? 1 : r_stride[7:4];
		sh = (r_stride[3:0] == 0) ? 1 : r_stride[3:0];
		pv = r_pad[7:4];
		ph = r_pad[3:0];
		if (cur_row >= h)
			cur_row = 0;
		if (cur_col >= w)
			cur_col = 0;
		row_buf[(cur_row % EXT) * MAXW + cur_col] = s;
		axis_windows(cur_row, h, oh, kh, sv, pv, dv, rows, nr);
		axis_windows(cur_col, w, ow, kw, sh, ph, dh, cols, nc);
		n = 0;
		for (int i = 0; i < nr; i++) begin
			for (int j = 0; j < nc; j++) begin
				if (n >= WIN_CAP)
					break;
				br = rows[i] * sv - pv;
				bc = cols[j] * sh - ph;
				have = 1'b0;
				best = '0;
				bidx = '0;
				for (int ky = 0; ky < kh; ky++) begin
					y = br + ky * dv;
					if (y < 0 || y >= h)
						continue;
					for (int kx = 0; kx < kw; kx++) begin
						x = bc + kx * dh;
						if (x < 0 || x >= w)
							continue;
						if (!have || row_buf[(y % EXT) * MAXW + x] > best) begin
							have = 1'b1;
							best = row_buf[(y % EXT) * MAXW + x];
							bidx = r_col_major ? x * h + y : y * w + x;
						end
					end
				end
				res.value = best;
				res.index = bidx[INDEX_W-1:0];
				res.row = OUT_POS_W'(rows[i]);
				res.col = OUT_POS_W'(cols[j]);
				res.last = 1'b0;
				pending_windows = {pending_windows, res};
				n++;
			end
		end
		// The plane's final sample flags only the last window it completes.
		if (cur_row == h - 1 && cur_col == w - 1 && n > 0)
			pending_windows[$].last = 1'b1;
		if (cur_col + 1 >= w) begin
			cur_col = 0;
			cur_row = (cur_row + 1 >= h) ? 0 : cur_row + 1;
		end else begin
			cur_col = cur_col + 1;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			pool_sample(sample);
			samples_sent++;
		end
	end

	// Result checker.
	always @(posedge clk) begin
		pool_res_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{max_value, max_index, out_row, out_col, last};
			results_seen++;
			if (pending_windows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected window row %0d col %0d value %0d index %0d",
						out_row, out_col, max_value, max_index);
			end else begin
				want = pending_windows.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"ERROR: window exp v=%0d i=%0d r=%0d c=%0d l=%0d",
							" got v=%0d i=%0d r=%0d c=%0d l=%0d"},
							want.value, want.index, want.row, want.col, want.last,
							got.value, got.index, got.row, got.col, got.last);
				end
			end
		end
	end

	// Receiver stall: random bursts, a long hold-off on request, none when calm.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_gap <= 0;
		end else if (hold_on) begin
			out_stall <= 1'b1;
		end else if (rx_gap > 0) begin
			out_stall <= 1'b1;
			rx_gap <= rx_gap - 1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			rx_gap <= $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d windows outstanding",
				cycles, pending_windows.size());
			$display("max_pool_2d_argmax verification failed");
			$finish;
		end
	end

	task automatic push_sample(input logic signed [15:0] v);
		int gap;
		in_valid <= 1'b1;
		sample <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			sample <= 16'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_windows.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller drops it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_IN_SIZE: r_in_size = val;
			REG_OUT_SIZE: r_out_size = val;
			REG_KERNEL: r_kernel = val[7:0];
			REG_STRIDE: r_stride = val[7:0];
			REG_PAD: r_pad = val[7:0];
			REG_DILATION: r_dilation = val[7:0];
			REG_INDEX_ORDER: r_col_major = val[0];
			default: ;
		endcase
		cur_row = 0;
		cur_col = 0;
		configs_done++;
	endtask

	task automatic set_geometry(input int h, input int w, input int oh, input int ow,
			input logic [7:0] k, input logic [7:0] st, input logic [7:0] p,
			input logic [7:0] d, input bit col_major);
		go_idle();
		wait_drained();
		write_reg(REG_IN_SIZE, {h[11:0], w[11:0]});
		write_reg(REG_OUT_SIZE, {oh[11:0], ow[11:0]});
		write_reg(REG_KERNEL, {16'($urandom_range(0, 65535)), k});
		write_reg(REG_STRIDE, {16'h0, st});
		write_reg(REG_PAD, {16'($urandom_range(0, 65535)), p});
		write_reg(REG_DILATION, {16'h0, d});
		write_reg(REG_INDEX_ORDER, {23'($urandom_range(0, 8388607)), col_major});
		cfg_we <= 1'b0;
	endtask

	task automatic send_random_plane(input int count);
		for (int i = 0; i < count; i++)
			push_sample(16'($urandom));
	endtask

	// Default 1x1 plane after reset: each sample is its own window.
	task automatic test_reset_defaults();
		push_sample(16'sh8000);
		push_sample(16'sh7fff);
		push_sample(16'sh0000);
		push_sample(16'shffff);
	endtask

	// 4x4 plane, 2x2 windows, ties and all-minimum windows.
	task automatic test_basic_pool();
		logic signed [15:0] vals [16] = '{16'sh8000, 16'sh8000, 5, 5, 16'sh8000, 16'sh8000,
			7, 5, 16'sh7fff, 3, 0, 0, 2, 16'sh7fff, 0, 0};
		set_geometry(4, 4, 2, 2, 8'h22, 8'h22, 8'h00, 8'h11, 1'b0);
		foreach (vals[i])
			push_sample(vals[i]);
	endtask

	// Padding, dilation, column-major index, zero fields and oversized kernel.
	task automatic test_pad_dilation();
		set_geometry(3, 5, 3, 4, 8'h23, 8'h12, 8'h11, 8'h12, 1'b1);
		send_random_plane(15);
		set_geometry(0, 3, 1, 5, 8'h0F, 8'h00, 8'h01, 8'h00, 1'b0);
		send_random_plane(3);
		// No output windows: nothing is emitted and no last flag appears.
		set_geometry(2, 2, 0, 0, 8'h11, 8'h11, 8'h00, 8'h11, 1'b0);
		send_random_plane(4);
	endtask

	// Sizes, kernel and stride at their widest settings; only a few samples of a 1024-wide row.
	task automatic test_extremes();
		set_geometry(4095, 4095, 4095, 4095, 8'hFF, 8'hFF, 8'h77, 8'h11, 1'b1);
		send_random_plane(10);
		set_geometry(4095, 4095, 4095, 4095, 8'h11, 8'hFF, 8'h00, 8'hFF, 1'b0);
		send_random_plane(6);
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering.
	task automatic test_backpressure();
		set_geometry(5, 5, 5, 5, 8'h33, 8'h11, 8'h11, 8'h11, 1'b0);
		hold_on <= 1'b1;
		fork
			begin
				repeat (600) @(posedge clk);
				hold_on <= 1'b0;
			end
		join_none
		send_random_plane(25);
		// Sender pauses until every window is back, then finishes another plane.
		go_idle();
		wait_drained();
		send_random_plane(25);
	endtask

	task automatic test_random_planes(input int budget);
		int h, w, kh, kw, dv, dh, ev, eh, count;
		int start;
		start = samples_sent;
		while (samples_sent - start < budget) begin
			h = $urandom_range(1, 6);
			w = $urandom_range(1, 7);
			kh = $urandom_range(0, 4);
			kw = $urandom_range(0, 4);
			dv = $urandom_range(0, 2);
			dh = $urandom_range(0, 2);
			ev = ((kh == 0 ? 1 : kh) - 1) * (dv == 0 ? 1 : dv) + 1;
			eh = ((kw == 0 ? 1 : kw) - 1) * (dh == 0 ? 1 : dh) + 1;
			if (ev > EXT)
				ev = EXT;
			if (eh > EXT)
				eh = EXT;
			set_geometry(h, w, $urandom_range(0, 8), $urandom_range(0, 8),
				{kh[3:0], kw[3:0]},
				{4'($urandom_range(0, 3)), 4'($urandom_range(0, 3))},
				{4'($urandom_range(0, ev - 1)), 4'($urandom_range(0, eh - 1))},
				{dv[3:0], dh[3:0]}, $urandom_range(0, 1));
			// Mostly whole planes, sometimes one and a half or a cut-off plane.
			case ($urandom_range(0, 3))
				0: count = h * w + (h * w) / 2;
				1: count = $urandom_range(1, h * w);
				default: count = h * w;
			endcase
			send_random_plane(count);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample = '0;
		calm = 1'b0;
		hold_on = 1'b0;
		mismatches = 0;
		results_seen = 0;
		samples_sent = 0;
		configs_done = 0;
		cycles = 0;
		cur_row = 0;
		cur_col = 0;
		r_in_size = 24'd4097;
		r_out_size = 24'd4097;
		r_kernel = 8'h11;
		r_stride = 8'h11;
		r_pad = 8'h00;
		r_dilation = 8'h11;
		r_col_major = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_basic_pool();
		test_pad_dilation();
		test_extremes();
		test_backpressure();
		test_random_planes(35);
		calm = 1'b1;
		test_random_planes(15);

		go_idle();
		wait_drained();
		$display("Covered %0d samples, %0d windows checked, %0d register writes.",
			samples_sent, results_seen, configs_done);
		if (mismatches == 0) begin
			$display("max_pool_2d_argmax verification clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("max_pool_2d_argmax verification failed");
		end
		$finish;
	end

endmodule
